### hw/rtl/pml_pkg.sv
// ----------------------------------------------------------------------------
// pml_pkg
// Shared types and constants for the peak meter with LED ladder.
// ----------------------------------------------------------------------------
package pml_pkg;

    localparam int unsigned SAMPLE_W      = 25;
    localparam int unsigned HOLD_W        = 8;
    localparam int unsigned LED_W         = 4;
    localparam int unsigned CNT_W         = 5;
    localparam int unsigned LVL_TABLE_LEN = 26;
    localparam int unsigned THR_W         = 33;

    localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = 8'd10;
    localparam logic [LED_W-1:0]  LED_SAT        = 4'd15;

    // floor(2^31 * 10^(dB/20)) for dB = -78 .. -3 in 3 dB steps
    localparam logic [31:0] LVL_Q31 [LVL_TABLE_LEN] = '{
        32'd270352,     32'd381882,     32'd539423,     32'd761955,
        32'd1076291,    32'd1520301,    32'd2147483,    32'd3033401,
        32'd4284793,    32'd6052431,    32'd8549286,    32'd12076188,
        32'd17058068,   32'd24095162,   32'd34035322,   32'd48076170,
        32'd67909395,   32'd95924570,   32'd135497057,  32'd191394681,
        32'd270352173,  32'd381882595,  32'd539423503,  32'd761955951,
        32'd1076291388, 32'd1520301995
    };

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [LED_W-1:0] led_count;
        logic             overload;
    } t_level_stat;

endpackage

### hw/rtl/pml_intf.sv
// ----------------------------------------------------------------------------
// pml_intf
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface pml_in_if;
    logic                             valid;
    logic                             ready;
    logic                             opcode;
    logic signed [pml_pkg::SAMPLE_W-1:0] sample;
    logic                             last_in_block;

    modport source (output valid, output opcode, output sample, output last_in_block,
                    input ready);
    modport sink   (input valid, input opcode, input sample, input last_in_block,
                    output ready);
endinterface

interface pml_out_if;
    logic                          valid;
    logic                          ready;
    logic [pml_pkg::LED_W-1:0]     led_count;
    logic                          over_lit;
    logic [pml_pkg::SAMPLE_W-1:0]  peak_level;

    modport source (output valid, output led_count, output over_lit, output peak_level,
                    input ready);
    modport sink   (input valid, input led_count, input over_lit, input peak_level,
                    output ready);
endinterface

### hw/rtl/pml_level.sv
// ----------------------------------------------------------------------------
// pml_level
// Threshold ladder: LED count and overload flag for a held peak.
// ----------------------------------------------------------------------------
module pml_level #(
    parameter int unsigned NUM_LEDS  = 13,
    parameter int unsigned FRAC_BITS = 23
) (
    input  logic [pml_pkg::SAMPLE_W-1:0] i_peak,
    output pml_pkg::t_level_stat         o_stat
);

    localparam int unsigned FIRST = pml_pkg::LVL_TABLE_LEN - NUM_LEDS;
    localparam logic [pml_pkg::THR_W-1:0] FULL_SCALE =
        pml_pkg::THR_W'(64'd1 << FRAC_BITS);

    logic [pml_pkg::THR_W-1:0] peak_ext;
    logic [NUM_LEDS-1:0]       lit;
    logic [pml_pkg::CNT_W-1:0] cnt;

    assign peak_ext = pml_pkg::THR_W'(i_peak);

    for (genvar g = 0; g < NUM_LEDS; g++) begin : g_thr
        localparam logic [pml_pkg::THR_W-1:0] THR =
            (pml_pkg::THR_W'(pml_pkg::LVL_Q31[FIRST + g]) >> (31 - FRAC_BITS))
            + pml_pkg::THR_W'(1);
        assign lit[g] = (peak_ext >= THR);
    end

    always_comb begin
        cnt = '0;
        for (int k = 0; k < NUM_LEDS; k++) begin
            cnt = cnt + pml_pkg::CNT_W'(lit[k]);
        end
    end

    always_comb begin
        o_stat.led_count = (cnt > pml_pkg::CNT_W'(pml_pkg::LED_SAT)) ?
                           pml_pkg::LED_SAT : cnt[pml_pkg::LED_W-1:0];
        o_stat.overload  = (peak_ext >= FULL_SCALE);
    end

endmodule

### hw/rtl/peak_meter_led_ladder.sv
// ----------------------------------------------------------------------------
// peak_meter_led_ladder
// Peak level meter with an LED threshold ladder and overload hold.
// ----------------------------------------------------------------------------
// usage:
//   i_in carries sample transactions (opcode sample) and refresh ticks
//   (opcode tick). samples update the running block maximum; the one marked
//   last_in_block latches it as the held peak. a tick advances the overload
//   hold counter and returns one transaction on o_out with led_count,
//   over_lit and peak_level. samples return nothing.
//   i_cfg_we/i_cfg_data write hold_ticks; write it only while idle.
// timing:
//   one transaction per cycle sustained while no tick waits on a stalled o_out.
//   an input register feeds the state update and ladder compare, whose result
//   lands in the output register: a tick's result is valid there once it leaves the input register.
// reset:
//   synchronous, active low; clears the maxima, the hold counter, the
//   pipeline valids, and sets hold_ticks to 10.
// stall:
//   while o_out is stalled, samples keep flowing; a tick waits in the input
//   register and i_in.ready drops behind it.
// ----------------------------------------------------------------------------
module peak_meter_led_ladder #(
    parameter int unsigned NUM_LEDS  = 13,
    parameter int unsigned FRAC_BITS = 23
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pml_pkg::HOLD_W-1:0] i_cfg_data,
    pml_in_if.sink                     i_in,
    pml_out_if.source                  o_out
);

    logic                                r_s1_valid;
    pml_pkg::t_opcode                    r_s1_op;
    logic [pml_pkg::SAMPLE_W-1:0]        r_s1_sample;
    logic                                r_s1_last;

    logic [pml_pkg::HOLD_W-1:0]          r_hold_ticks;
    logic [pml_pkg::SAMPLE_W-1:0]        r_running_max;
    logic [pml_pkg::SAMPLE_W-1:0]        r_held_peak;
    logic [pml_pkg::HOLD_W-1:0]          r_hold_count;

    logic                                r_out_valid;
    logic [pml_pkg::LED_W-1:0]           r_led_count;
    logic                                r_over_lit;
    logic [pml_pkg::SAMPLE_W-1:0]        r_peak_level;

    logic                                out_free;
    logic                                s1_go;
    logic                                in_acc;
    logic [pml_pkg::SAMPLE_W-1:0]        mag;
    logic [pml_pkg::SAMPLE_W-1:0]        blockmax;
    logic [pml_pkg::HOLD_W-1:0]          n_hold_count;
    pml_pkg::t_level_stat                stat;

    pml_level #(
        .NUM_LEDS  (NUM_LEDS),
        .FRAC_BITS (FRAC_BITS)
    ) u_level (
        .i_peak (r_held_peak),
        .o_stat (stat)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_go      = r_s1_valid && ((r_s1_op == pml_pkg::OP_SAMPLE) || out_free);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_acc     = i_in.valid && i_in.ready;

    always_comb begin
        mag      = r_s1_sample[pml_pkg::SAMPLE_W-1] ? (~r_s1_sample + 1'b1) : r_s1_sample;
        blockmax = (r_running_max > mag) ? r_running_max : mag;
    end

    always_comb begin
        if (stat.overload) begin
            n_hold_count = pml_pkg::HOLD_W'(1);
        end else if (r_hold_count != '0) begin
            n_hold_count = r_hold_count + 1'b1;
        end else begin
            n_hold_count = r_hold_count;
        end
        if (n_hold_count >= r_hold_ticks) begin
            n_hold_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op     <= pml_pkg::t_opcode'(i_in.opcode);
            r_s1_sample <= i_in.sample;
            r_s1_last   <= i_in.last_in_block;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks <= pml_pkg::HOLD_TICKS_RST;
        end else if (i_cfg_we) begin
            r_hold_ticks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_max <= '0;
            r_held_peak   <= '0;
            r_hold_count  <= '0;
        end else if (s1_go) begin
            if (r_s1_op == pml_pkg::OP_SAMPLE) begin
                if (r_s1_last) begin
                    r_held_peak   <= blockmax;
                    r_running_max <= '0;
                end else begin
                    r_running_max <= blockmax;
                end
            end else begin
                r_hold_count <= n_hold_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && (r_s1_op == pml_pkg::OP_TICK)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && (r_s1_op == pml_pkg::OP_TICK)) begin
            r_led_count  <= stat.led_count;
            r_over_lit   <= (n_hold_count != '0);
            r_peak_level <= r_held_peak;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.led_count  = r_led_count;
    assign o_out.over_lit   = r_over_lit;
    assign o_out.peak_level = r_peak_level;

endmodule

### hw/rtl/pml_checker.sv
// ----------------------------------------------------------------------------
// pml_checker
// Port-level checks for the peak meter, bound to the top level.
// ----------------------------------------------------------------------------
module pml_checker #(
    parameter int unsigned NUM_LEDS  = 13,
    parameter int unsigned FRAC_BITS = 23
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [pml_pkg::LED_W-1:0]    i_led_count,
    input logic [pml_pkg::SAMPLE_W-1:0] i_peak_level
);

    localparam logic [pml_pkg::LED_W-1:0] LED_MAX =
        (NUM_LEDS > 15) ? pml_pkg::LED_SAT : pml_pkg::LED_W'(NUM_LEDS);
    localparam logic [pml_pkg::THR_W-1:0] FULL_SCALE =
        pml_pkg::THR_W'(64'd1 << FRAC_BITS);
    localparam logic [pml_pkg::SAMPLE_W-1:0] MAG_MAX =
        pml_pkg::SAMPLE_W'(1) << (pml_pkg::SAMPLE_W - 1);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result transaction dropped while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_led_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_led_count <= LED_MAX)
        else $error("led count above ladder size");

    a_full_ladder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (pml_pkg::THR_W'(i_peak_level) >= FULL_SCALE)
        |-> i_led_count == LED_MAX)
        else $error("overload peak without full ladder");

    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_peak_level <= MAG_MAX)
        else $error("peak above largest magnitude");

endmodule

bind peak_meter_led_ladder pml_checker #(
    .NUM_LEDS  (NUM_LEDS),
    .FRAC_BITS (FRAC_BITS)
) u_pml_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_led_count  (o_out.led_count),
    .i_peak_level (o_out.peak_level)
);

### verif/peak_meter_led_ladder_tb.sv
// ----------------------------------------------------------------------------
// peak_meter_led_ladder_tb
// Self-checking bench for the peak meter with LED ladder and overload hold.
// Sample and tick transactions are sent in bursts with random gaps, and the
// result channel stalls on its own pattern, with long hold-offs that back
// the block up. A scoreboard class keeps its own copy of the meter state,
// predicts each tick readout and compares it field by field with the block.
// ----------------------------------------------------------------------------
module peak_meter_led_ladder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_LEDS      = 13;
    localparam int unsigned FRAC_BITS     = 23;
    localparam int unsigned SAMPLE_W      = pml_pkg::SAMPLE_W;
    localparam int unsigned LED_W         = pml_pkg::LED_W;
    localparam int unsigned HOLD_W        = pml_pkg::HOLD_W;
    localparam int unsigned LVL_TABLE_LEN = pml_pkg::LVL_TABLE_LEN;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 25'h0800000;
    localparam logic [SAMPLE_W-1:0] MAG_MAX    = 25'h1000000;

    typedef struct packed {
        logic [LED_W-1:0]    led_count;
        logic                over_lit;
        logic [SAMPLE_W-1:0] peak_level;
    } t_readout;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [HOLD_W-1:0]  i_cfg_data;

    pml_in_if  in_ch ();
    pml_out_if out_ch ();

    peak_meter_led_ladder #(
        .NUM_LEDS  (NUM_LEDS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    function automatic logic [31:0] led_threshold(int idx);
        return (pml_pkg::LVL_Q31[idx] >> (31 - FRAC_BITS)) + 32'd1;
    endfunction

    class meter_readout_checker;
        logic [HOLD_W-1:0]   hold_ticks;
        logic [SAMPLE_W-1:0] running_max;
        logic [SAMPLE_W-1:0] held_peak;
        logic [HOLD_W-1:0]   hold_count;
        t_readout            pending_readouts[$];
        int                  errors;
        int                  samples_seen;
        int                  ticks_seen;
        int                  readouts_checked;
        int                  overload_readouts;
        int                  hold_settings;

        function void clear();
            hold_ticks        = pml_pkg::HOLD_TICKS_RST;
            running_max       = '0;
            held_peak         = '0;
            hold_count        = '0;
            pending_readouts  = {};
            errors            = 0;
            samples_seen      = 0;
            ticks_seen        = 0;
            readouts_checked  = 0;
            overload_readouts = 0;
            hold_settings     = 0;
        endfunction

        function void write_hold_ticks(logic [HOLD_W-1:0] value);
            hold_ticks = value;
            hold_settings++;
        endfunction

        function logic [LED_W-1:0] lit_leds(logic [SAMPLE_W-1:0] peak);
            int n;
            n = 0;
            for (int idx = LVL_TABLE_LEN - NUM_LEDS; idx < LVL_TABLE_LEN; idx++) begin
                if ({7'd0, peak} >= led_threshold(idx)) begin
                    n++;
                end
            end
            return (n > 15) ? pml_pkg::LED_SAT : LED_W'(n);
        endfunction

        function void note_transaction(pml_pkg::t_opcode op,
                                       logic signed [SAMPLE_W-1:0] smp, logic last);
            logic [SAMPLE_W-1:0] mag;
            logic [SAMPLE_W-1:0] block_max;
            t_readout            rd;
            if (op == pml_pkg::OP_SAMPLE) begin
                samples_seen++;
                mag       = smp[SAMPLE_W-1] ? SAMPLE_W'(25'd0 - smp) : smp;
                block_max = (running_max > mag) ? running_max : mag;
                if (last) begin
                    held_peak   = block_max;
                    running_max = '0;
                end else begin
                    running_max = block_max;
                end
            end else begin
                ticks_seen++;
                if (held_peak >= FULL_SCALE) begin
                    hold_count = 8'd1;
                end else if (hold_count != 0) begin
                    hold_count = hold_count + 8'd1;
                end
                if (hold_count >= hold_ticks) begin
                    hold_count = '0;
                end
                rd.led_count  = lit_leds(held_peak);
                rd.over_lit   = (hold_count != 0);
                rd.peak_level = held_peak;
                if (rd.over_lit) begin
                    overload_readouts++;
                end
                pending_readouts.push_back(rd);
            end
        endfunction

        function void check_readout(t_readout got);
            t_readout exp_rd;
            if (pending_readouts.size() == 0) begin
                $error("unexpected readout: led_count %0d over_lit %0d peak_level %0d",
                       got.led_count, got.over_lit, got.peak_level);
                errors++;
                return;
            end
            exp_rd = pending_readouts.pop_front();
            readouts_checked++;
            if (got.led_count !== exp_rd.led_count) begin
                $error("led_count mismatch: expected %0d, actual %0d",
                       exp_rd.led_count, got.led_count);
                errors++;
            end
            if (got.over_lit !== exp_rd.over_lit) begin
                $error("over_lit mismatch: expected %0d, actual %0d",
                       exp_rd.over_lit, got.over_lit);
                errors++;
            end
            if (got.peak_level !== exp_rd.peak_level) begin
                $error("peak_level mismatch: expected %0d, actual %0d",
                       exp_rd.peak_level, got.peak_level);
                errors++;
            end
        endfunction

        function void check_drained();
            if (pending_readouts.size() != 0) begin
                $error("%0d readouts never arrived", pending_readouts.size());
                errors++;
            end
        endfunction
    endclass

    meter_readout_checker meter_sb;
    int                   burst_left;
    bit                   hold_off_req;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // transaction monitors
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            meter_sb.note_transaction(pml_pkg::t_opcode'(in_ch.opcode), in_ch.sample,
                                      in_ch.last_in_block);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            meter_sb.check_readout({out_ch.led_count, out_ch.over_lit, out_ch.peak_level});
        end
    end

    // receiver stall pattern, with long hold-offs on request
    initial begin
        int          hold_left;
        int          bit_idx;
        logic [15:0] pattern;
        hold_left     = 0;
        bit_idx       = 0;
        pattern       = '1;
        out_ch.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = $urandom_range(80, 140);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (bit_idx == 0) begin
                    case ($urandom_range(0, 3))
                        0:       pattern = '1;
                        1:       pattern = 16'($urandom);
                        2:       pattern = 16'($urandom) & 16'($urandom) & 16'($urandom);
                        default: pattern = 16'($urandom) | 16'($urandom);
                    endcase
                end
                out_ch.ready <= pattern[bit_idx];
                bit_idx       = (bit_idx + 1) % 16;
            end
        end
    end

    task automatic send_item(pml_pkg::t_opcode op, logic signed [SAMPLE_W-1:0] smp,
                             logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= op;
        in_ch.sample        <= smp;
        in_ch.last_in_block <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
    endtask

    task automatic send_tick();
        send_item(pml_pkg::OP_TICK, SAMPLE_W'($urandom), 1'($urandom));
    endtask

    function automatic logic signed [SAMPLE_W-1:0] to_sample(logic [SAMPLE_W-1:0] mag);
        if (mag == MAG_MAX || (mag != 0 && $urandom_range(0, 1) == 1)) begin
            return SAMPLE_W'(25'd0 - mag);
        end
        return mag;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_level();
        int idx;
        case ($urandom_range(0, 9))
            0: return '0;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return FULL_SCALE;
                    1:       return FULL_SCALE - 25'd1;
                    2:       return MAG_MAX;
                    default: return MAG_MAX - 25'd1;
                endcase
            end
            2, 3, 4: begin
                idx = $urandom_range(LVL_TABLE_LEN - NUM_LEDS, LVL_TABLE_LEN - 1);
                return SAMPLE_W'(led_threshold(idx) - $urandom_range(0, 1));
            end
            5:       return SAMPLE_W'($urandom_range(0, FULL_SCALE));
            6:       return SAMPLE_W'($urandom_range(0, 16'hFFFF));
            default: return SAMPLE_W'($urandom_range(0, MAG_MAX));
        endcase
    endfunction

    task automatic send_block(int len, bit closed);
        for (int i = 0; i < len; i++) begin
            send_item(pml_pkg::OP_SAMPLE, to_sample(random_level()),
                      closed && (i == len - 1));
        end
    endtask

    task automatic release_input();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_drained();
        while (meter_sb.pending_readouts.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_hold_ticks(logic [HOLD_W-1:0] value);
        release_input();
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        meter_sb.write_hold_ticks(value);
    endtask

    task automatic run_traffic(int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                7: begin
                    // noise
                    send_item(pml_pkg::t_opcode'($urandom_range(0, 1)),
                              SAMPLE_W'($urandom), 1'($urandom));
                    sent++;
                end
                8: begin
                    // unterminated block, then a tick
                    len = $urandom_range(1, 4);
                    send_block(len, 1'b0);
                    send_tick();
                    sent += len + 1;
                end
                9: begin
                    len = $urandom_range(1, 12);
                    repeat (len) send_tick();
                    sent += len;
                end
                default: begin
                    len = $urandom_range(1, 6);
                    send_block(len, 1'b1);
                    sent += len;
                    len = $urandom_range(1, 3);
                    repeat (len) send_tick();
                    sent += len;
                end
            endcase
        end
    endtask

    // directed cases: extremes, ignored tick fields, ladder edges, full scale
    task automatic run_directed();
        send_tick();
        send_item(pml_pkg::OP_SAMPLE, 25'sh0FFFFFF, 1'b1);
        send_tick();
        send_item(pml_pkg::OP_SAMPLE, 25'sh1000000, 1'b1);
        send_tick();
        send_item(pml_pkg::OP_SAMPLE, '0, 1'b1);
        send_item(pml_pkg::OP_TICK, 25'sh1FFFFFF, 1'b1);
        send_item(pml_pkg::OP_TICK, 25'sh1000000, 1'b0);
        send_item(pml_pkg::OP_SAMPLE,
                  SAMPLE_W'(led_threshold(LVL_TABLE_LEN - NUM_LEDS) - 1), 1'b0);
        send_item(pml_pkg::OP_SAMPLE,
                  SAMPLE_W'(25'd0 - led_threshold(LVL_TABLE_LEN - NUM_LEDS)), 1'b0);
        send_item(pml_pkg::OP_SAMPLE, 25'sd5, 1'b1);
        send_tick();
        send_item(pml_pkg::OP_SAMPLE, SAMPLE_W'(led_threshold(LVL_TABLE_LEN - 1)), 1'b1);
        send_tick();
        send_item(pml_pkg::OP_SAMPLE, SAMPLE_W'(led_threshold(LVL_TABLE_LEN - 1) - 1),
                  1'b1);
        send_tick();
        send_item(pml_pkg::OP_SAMPLE, FULL_SCALE, 1'b1);
        send_tick();
        send_item(pml_pkg::OP_SAMPLE, SAMPLE_W'(25'd0 - (FULL_SCALE - 25'd1)), 1'b1);
        send_tick();
        send_tick();
        send_item(pml_pkg::OP_SAMPLE, 25'sh1FFFFFF, 1'b1);
        send_tick();
    endtask

    initial begin
        meter_sb = new;
        meter_sb.clear();
        burst_left          = 0;
        hold_off_req        = 1'b0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_data          = pml_pkg::HOLD_TICKS_RST;
        in_ch.valid         = 1'b0;
        in_ch.opcode        = pml_pkg::OP_SAMPLE;
        in_ch.sample        = '0;
        in_ch.last_in_block = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        set_hold_ticks(8'd2);
        hold_off_req = 1'b1;
        run_traffic(150);

        // longest hold: overload once, then let the counter run out
        set_hold_ticks(8'd255);
        send_item(pml_pkg::OP_SAMPLE, to_sample(FULL_SCALE), 1'b1);
        send_tick();
        send_item(pml_pkg::OP_SAMPLE, 25'sd100, 1'b1);
        repeat (258) send_tick();

        repeat (3) begin
            set_hold_ticks(HOLD_W'($urandom_range(3, 254)));
            hold_off_req = 1'b1;
            run_traffic(110);
        end

        release_input();
        wait_drained();
        meter_sb.check_drained();
        $display("covered %0d samples and %0d ticks over %0d hold settings",
                 meter_sb.samples_seen, meter_sb.ticks_seen, meter_sb.hold_settings);
        $display("checked %0d readouts, %0d with the overload indicator lit",
                 meter_sb.readouts_checked, meter_sb.overload_readouts);
        if (meter_sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/pml_pkg.sv
hw/rtl/pml_intf.sv
hw/rtl/pml_level.sv
hw/rtl/peak_meter_led_ladder.sv
hw/rtl/pml_checker.sv
verif/peak_meter_led_ladder_tb.sv
